// ===== sv/consensus_quorum_learner_macros.svh =====
// Assertion macros shared by the consensus quorum learner RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef CONSENSUS_QUORUM_LEARNER_MACROS_SVH
`define CONSENSUS_QUORUM_LEARNER_MACROS_SVH

// Checked on every clock edge outside reset.
`define CQL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define CQL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/cql_pkg.sv =====
// Package of the consensus quorum learner: sizes, item types, slot records.
// No dependencies; used by every module of the block but cql_ram.
`timescale 1ns / 1ps
package cql_pkg;

  localparam int unsigned ACCEPTORS = 3;
  // Window depth; a power of two so the slot is the low instance bits.
  localparam int unsigned WINDOW    = 64;
  localparam int unsigned SLOT_W    = $clog2(WINDOW);
  localparam int unsigned ACC_IDX_W = $clog2(ACCEPTORS);
  localparam int unsigned CNT_W     = $clog2(ACCEPTORS + 1);
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);
  localparam logic [1:0]  QUORUM_RESET = 2'd2;

  typedef struct packed {
    logic [1:0]  acceptor_index;
    logic [31:0] instance_number;
    logic [15:0] ballot_number;
    logic [31:0] value_handle;
    logic [15:0] value_length;
  } in_item_t;

  typedef struct packed {
    logic [31:0] delivered_instance;
    logic [15:0] delivered_ballot;
    logic [31:0] delivered_handle;
    logic [15:0] delivered_length;
    logic        last_of_run;
  } out_item_t;

  // One stored acknowledgement.
  typedef struct packed {
    logic [15:0] ballot;
    logic [31:0] handle;
    logic [15:0] length;
  } ack_t;

  typedef ack_t [ACCEPTORS-1:0] ack_row_t;

  // Per-slot record held in memory; only meaningful while the slot is used.
  typedef struct packed {
    logic [31:0]          inst;
    logic [15:0]          latest;
    logic [ACC_IDX_W-1:0] chosen;
  } slot_t;

  // Classified item as queued between front and back.
  typedef struct packed {
    logic [ACC_IDX_W-1:0] acc;
    logic [SLOT_W-1:0]    slot;
    in_item_t             item;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } q_head_t;

endpackage

// ===== sv/cql_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cql_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cql_front.sv =====
// Front end: accepts acks, drops bad acceptor indexes, queues the rest.
// Depends on cql_pkg.
`timescale 1ns / 1ps
module cql_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cql_pkg::in_item_t in_data_i,
  output cql_pkg::q_head_t  head_o,
  input  logic              pop_i
);

  cql_pkg::work_t                 q_mem_q [cql_pkg::QDEPTH];
  logic [cql_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [cql_pkg::QCNT_W-1:0]     cnt_q;
  logic                           acc_ok, push, pop;
  cql_pkg::work_t                 work;

  assign in_ready_o = (cnt_q != cql_pkg::QCNT_W'(cql_pkg::QDEPTH));
  assign acc_ok = ({30'd0, in_data_i.acceptor_index} < 32'(cql_pkg::ACCEPTORS));
  assign push = in_valid_i && in_ready_o && acc_ok;
  assign pop  = pop_i && (cnt_q != '0);

  always_comb begin
    work.acc  = cql_pkg::ACC_IDX_W'(in_data_i.acceptor_index);
    work.slot = in_data_i.instance_number[cql_pkg::SLOT_W-1:0];
    work.item = in_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= work;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.work  = q_mem_q[rd_ptr_q];

endmodule

// ===== sv/cql_back.sv =====
// Back end: window check, ack store, quorum count and in-order delivery.
// Depends on cql_pkg, cql_ram and the assertion macros header.
`timescale 1ns / 1ps
`include "consensus_quorum_learner_macros.svh"
module cql_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         quorum_i,
  input  cql_pkg::q_head_t   head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cql_pkg::out_item_t out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_DRD  = 2'd2;
  localparam logic [1:0] S_DCHK = 2'd3;

  logic [1:0]                     state_q, state_d;
  cql_pkg::work_t                 cur_q, cur_d;
  logic [31:0]                    dt_q, dt_d;
  logic [cql_pkg::SLOT_W-1:0]     run_q, run_d;
  logic [cql_pkg::WINDOW-1:0]     used_q, closed_q;
  logic [cql_pkg::ACCEPTORS-1:0]  present_q [cql_pkg::WINDOW];
  cql_pkg::out_item_t             pend_q, pend_d, out_q, out_d;
  logic                           pend_valid_q, pend_valid_d, out_valid_q, out_valid_d;

  // slot bookkeeping updates
  logic                           set_en, set_close, wipe_en;
  logic [cql_pkg::SLOT_W-1:0]     wipe_slot;
  logic [cql_pkg::ACCEPTORS-1:0]  new_pres;

  // memories
  logic                           ram_re;
  logic [cql_pkg::SLOT_W-1:0]     ram_raddr;
  cql_pkg::slot_t                 slot_rd, slot_wr;
  cql_pkg::ack_row_t              row_rd, row_wr;

  // per-state helpers
  logic                           in_win, stale, drop_slot, close, ok, out_free;
  logic [31:0]                    stored_inst, nxt;
  logic [cql_pkg::SLOT_W-1:0]     t;
  logic [cql_pkg::CNT_W-1:0]      cnt, need;
  logic [cql_pkg::ACC_IDX_W-1:0]  chosen;
  cql_pkg::ack_t                  pick;

  cql_ram #(.WIDTH($bits(cql_pkg::slot_t)), .DEPTH(cql_pkg::WINDOW)) u_slot_ram (
    .clk_i, .we_i(set_en), .waddr_i(cur_q.slot), .wdata_i(slot_wr),
    .re_i(ram_re), .raddr_i(ram_raddr), .rdata_o(slot_rd)
  );

  cql_ram #(.WIDTH($bits(cql_pkg::ack_row_t)), .DEPTH(cql_pkg::WINDOW)) u_ack_ram (
    .clk_i, .we_i(set_en), .waddr_i(cur_q.slot), .wdata_i(row_wr),
    .re_i(ram_re), .raddr_i(ram_raddr), .rdata_o(row_rd)
  );

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    dt_d         = dt_q;
    run_d        = run_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_free     = !out_valid_q || out_ready_i;
    pop_o        = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = head_i.work.slot;
    set_en       = 1'b0;
    set_close    = 1'b0;
    wipe_en      = 1'b0;

    in_win = (head_i.work.item.instance_number > dt_q) &&
             ({1'b0, head_i.work.item.instance_number} <
              ({1'b0, dt_q} + 33'(cql_pkg::WINDOW)));

    // ack merge and quorum count for the current item
    stored_inst = used_q[cur_q.slot] ? slot_rd.inst : cur_q.item.instance_number;
    drop_slot   = (stored_inst != cur_q.item.instance_number) || closed_q[cur_q.slot];
    stale       = present_q[cur_q.slot][cur_q.acc] &&
                  (row_rd[cur_q.acc].ballot >= cur_q.item.ballot_number);
    row_wr      = row_rd;
    row_wr[cur_q.acc] = '{ballot: cur_q.item.ballot_number,
                          handle: cur_q.item.value_handle,
                          length: cur_q.item.value_length};
    new_pres    = present_q[cur_q.slot];
    new_pres[cur_q.acc] = 1'b1;
    cnt    = '0;
    chosen = '0;
    for (int a = 0; a < cql_pkg::ACCEPTORS; a++) begin
      if (new_pres[a] && row_wr[a].ballot == cur_q.item.ballot_number) begin
        cnt    = cnt + cql_pkg::CNT_W'(1);
        chosen = cql_pkg::ACC_IDX_W'(a);
      end
    end
    need  = (quorum_i == 2'd0) ? cql_pkg::CNT_W'(1) : cql_pkg::CNT_W'(quorum_i);
    close = (cnt >= need);
    slot_wr = '{inst: cur_q.item.instance_number, latest: cur_q.item.ballot_number,
                chosen: chosen};

    // delivery walk
    nxt       = dt_q + 32'd1;
    t         = nxt[cql_pkg::SLOT_W-1:0];
    wipe_slot = t;
    ok = closed_q[t] && used_q[t] && (slot_rd.inst == nxt) &&
         (run_q != cql_pkg::SLOT_W'(cql_pkg::WINDOW - 1)) && (dt_q != '1);
    pick = row_rd[slot_rd.chosen];

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          cur_d = head_i.work;
          if (in_win) begin
            ram_re  = 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_IDLE;
        if (!drop_slot && !stale) begin
          set_en    = 1'b1;
          set_close = close;
          if (close && cur_q.item.instance_number == nxt) begin
            run_d   = '0;
            state_d = S_DRD;
          end
        end
      end
      S_DRD: begin
        ram_re    = 1'b1;
        ram_raddr = t;
        state_d   = S_DCHK;
      end
      S_DCHK: begin
        if (ok) begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_d       = pend_q;
              out_valid_d = 1'b1;
            end
            pend_d = '{delivered_instance: nxt, delivered_ballot: pick.ballot,
                       delivered_handle: pick.handle, delivered_length: pick.length,
                       last_of_run: 1'b0};
            pend_valid_d = 1'b1;
            dt_d    = nxt;
            run_d   = run_q + 1'b1;
            wipe_en = 1'b1;
            state_d = S_DRD;
          end
        end else if (out_free) begin
          out_d             = pend_q;
          out_d.last_of_run = 1'b1;
          out_valid_d       = 1'b1;
          pend_valid_d      = 1'b0;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pend_q <= pend_d;
    out_q  <= out_d;
    run_q  <= run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dt_q         <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      used_q       <= '0;
      closed_q     <= '0;
      for (int i = 0; i < cql_pkg::WINDOW; i++) begin
        present_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      dt_q         <= dt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (set_en) begin
        used_q[cur_q.slot]    <= 1'b1;
        present_q[cur_q.slot] <= new_pres;
        if (set_close) closed_q[cur_q.slot] <= 1'b1;
      end
      if (wipe_en) begin
        used_q[wipe_slot]    <= 1'b0;
        closed_q[wipe_slot]  <= 1'b0;
        present_q[wipe_slot] <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CQL_ASSERT(a_closed_is_used, (closed_q & ~used_q) == '0, "closed slot not in use")
  `CQL_ASSERT(a_dt_step, (dt_q != $past(dt_q)) |-> (dt_q == $past(dt_q) + 32'd1), "delivery counter jumped")
  `CQL_ASSERT(a_dt_only_walk, (dt_q != $past(dt_q)) |-> ($past(state_q) == S_DCHK), "delivery counter moved outside walk")
  `CQL_ASSERT(a_pend_in_walk, pend_valid_q |-> (state_q == S_DRD || state_q == S_DCHK), "held delivery outside walk")
  `CQL_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

// ===== sv/consensus_quorum_learner.sv =====
// Consensus quorum learner top level: config register, front end, back end.
// Depends on cql_pkg, cql_front and cql_back.
`timescale 1ns / 1ps
// Usage:
//  - in channel (in_valid_i/in_ready_o/in_data_i): one accept ack per item.
//    Acks with a bad acceptor index are taken and dropped at the front.
//  - out channel (out_valid_o/out_ready_i/out_data_o): delivered instances
//    in increasing order; last_of_run marks the final delivery of an ack.
//  - cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i): quorum_size, always
//    ready; write it only while the block is idle.
// Timing: an ack taken at the input waits in the two-entry queue, and the
// back end then works on it in order: pop plus slot and ack memory read,
// then merge and quorum count. An ack outside the window is dropped at the
// pop. The back end takes no new ack while one is in work or a run is walked.
// A delivery run reads the slot memories for each instance walked, then
// checks that instance before it moves on to the next.
// Reset: all slots empty, nothing delivered, quorum_size 2; no clearing pass.
// Stall: a stalled receiver holds the output register and the held delivery;
// the front keeps taking acks until its queue is full.
module consensus_quorum_learner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cql_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cql_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i
);

  logic [1:0]       quorum_q;
  cql_pkg::q_head_t head;
  logic             pop;

  assign cfg_ready_o = 1'b1;

  // quorum_size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quorum_q <= cql_pkg::QUORUM_RESET;
    end else if (cfg_valid_i) begin
      quorum_q <= cfg_data_i;
    end
  end

  cql_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .head_o(head), .pop_i(pop)
  );

  cql_back u_back (
    .clk_i, .rst_ni, .quorum_i(quorum_q), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

// ===== bench/consensus_quorum_learner_tb.sv =====
// Testbench for consensus_quorum_learner: directed table plus random acks,
// checked against an in-bench learner prediction. Depends on cql_pkg and the RTL.
`timescale 1ns / 1ps
module consensus_quorum_learner_tb;

  localparam int SETTLE_CYC  = 40; // idle cycles before a cfg write and at the end
  localparam int DONT_CARE   = -1;

  typedef struct {
    cql_pkg::in_item_t ack;
    int                n_deliv;   // deliveries typed in, or DONT_CARE
  } table_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  cql_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  cql_pkg::out_item_t out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_data_i = '0;

  consensus_quorum_learner dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------- learner prediction ----------------
  logic [31:0]        lrn_inst    [cql_pkg::WINDOW];
  logic [15:0]        lrn_latest  [cql_pkg::WINDOW];
  logic               lrn_closed  [cql_pkg::WINDOW];
  logic [1:0]         lrn_chosen  [cql_pkg::WINDOW];
  logic               lrn_has_ack [cql_pkg::WINDOW][cql_pkg::ACCEPTORS];
  cql_pkg::ack_t      lrn_ack     [cql_pkg::WINDOW][cql_pkg::ACCEPTORS];
  logic [31:0]        lrn_through;
  logic [1:0]         lrn_quorum;
  cql_pkg::out_item_t pending_deliveries[$];
  int                 fail_count = 0;

  function automatic void learner_reset();
    for (int s = 0; s < cql_pkg::WINDOW; s++) begin
      lrn_inst[s] = '0;
      lrn_latest[s] = '0;
      lrn_closed[s] = 1'b0;
      lrn_chosen[s] = '0;
      for (int a = 0; a < cql_pkg::ACCEPTORS; a++) begin
        lrn_has_ack[s][a] = 1'b0;
        lrn_ack[s][a] = '0;
      end
    end
    lrn_through = '0;
    lrn_quorum = cql_pkg::QUORUM_RESET;
  endfunction

  // Applies one accepted ack; queues the deliveries it causes, returns their count.
  function automatic int learner_take_ack(cql_pkg::in_item_t ack);
    int s, t, cnt, chosen, need, n;
    logic [31:0] nxt;
    cql_pkg::out_item_t d;
    n = 0;
    if (ack.acceptor_index >= cql_pkg::ACCEPTORS) return 0;
    if (ack.instance_number <= lrn_through) return 0;
    if ({1'b0, ack.instance_number} >= {1'b0, lrn_through} + 33'(cql_pkg::WINDOW)) return 0;
    s = ack.instance_number % cql_pkg::WINDOW;
    if (lrn_inst[s] == 0) begin
      lrn_inst[s] = ack.instance_number;
      lrn_latest[s] = ack.ballot_number;
    end
    if (lrn_inst[s] != ack.instance_number || lrn_closed[s]) return 0;
    // stale or duplicate ballot from the same acceptor
    if (lrn_has_ack[s][ack.acceptor_index] &&
        lrn_ack[s][ack.acceptor_index].ballot >= ack.ballot_number) return 0;
    lrn_has_ack[s][ack.acceptor_index] = 1'b1;
    lrn_ack[s][ack.acceptor_index] = '{ack.ballot_number, ack.value_handle,
                                      ack.value_length};
    lrn_latest[s] = ack.ballot_number;
    cnt = 0;
    chosen = 0;
    for (int a = 0; a < cql_pkg::ACCEPTORS; a++) begin
      if (lrn_has_ack[s][a] && lrn_ack[s][a].ballot == lrn_latest[s]) begin
        chosen = a;  // highest matching acceptor wins
        cnt++;
      end
    end
    need = (lrn_quorum == 0) ? 1 : lrn_quorum;
    if (cnt < need) return 0;
    lrn_closed[s] = 1'b1;
    lrn_chosen[s] = chosen[1:0];
    if (ack.instance_number != lrn_through + 1) return 0;
    // walk the run of closed instances
    while (n < cql_pkg::WINDOW - 1 && lrn_through != 32'hFFFF_FFFF) begin
      nxt = lrn_through + 1;
      t = nxt % cql_pkg::WINDOW;
      if (!lrn_closed[t] || lrn_inst[t] != nxt) break;
      d.delivered_instance = nxt;
      d.delivered_ballot   = lrn_ack[t][lrn_chosen[t]].ballot;
      d.delivered_handle   = lrn_ack[t][lrn_chosen[t]].handle;
      d.delivered_length   = lrn_ack[t][lrn_chosen[t]].length;
      d.last_of_run        = 1'b0;
      pending_deliveries.push_back(d);
      n++;
      lrn_through = nxt;
      lrn_inst[t] = '0;
      lrn_latest[t] = '0;
      lrn_closed[t] = 1'b0;
      for (int a = 0; a < cql_pkg::ACCEPTORS; a++) lrn_has_ack[t][a] = 1'b0;
    end
    if (n > 0) pending_deliveries[$].last_of_run = 1'b1;
    return n;
  endfunction

  // ---------------- result checking ----------------
  always @(posedge clk_i) begin
    cql_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_deliveries.size() == 0) begin
        $error("unexpected delivery of instance %0d", out_data_o.delivered_instance);
        fail_count++;
      end else begin
        want = pending_deliveries.pop_front();
        if (out_data_o.delivered_instance !== want.delivered_instance) begin
          $error("delivered_instance: expected %0d, got %0d",
                 want.delivered_instance, out_data_o.delivered_instance);
          fail_count++;
        end
        if (out_data_o.delivered_ballot !== want.delivered_ballot) begin
          $error("delivered_ballot: expected %0d, got %0d",
                 want.delivered_ballot, out_data_o.delivered_ballot);
          fail_count++;
        end
        if (out_data_o.delivered_handle !== want.delivered_handle) begin
          $error("delivered_handle: expected %h, got %h",
                 want.delivered_handle, out_data_o.delivered_handle);
          fail_count++;
        end
        if (out_data_o.delivered_length !== want.delivered_length) begin
          $error("delivered_length: expected %0d, got %0d",
                 want.delivered_length, out_data_o.delivered_length);
          fail_count++;
        end
        if (out_data_o.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b",
                 want.last_of_run, out_data_o.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Receiver: mode redrawn at random (always ready, coin flip, mostly stalled).
  int rx_cycle = 0;
  int rx_mode  = 0;
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------- sender ----------------
  int burst_left = 0;

  // Drives one ack, holds it until taken, predicts it; returns the delivery count.
  task automatic send_ack(input cql_pkg::in_item_t ack, output int n_deliv);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i = 1'b1;
    in_data_i  = ack;
    do @(posedge clk_i); while (!in_ready_o);
    n_deliv = learner_take_ack(ack);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (pending_deliveries.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_quorum(input logic [1:0] q);
    drain();
    cfg_valid_i = 1'b1;
    cfg_data_i  = q;
    do @(posedge clk_i); while (!cfg_ready_o);
    lrn_quorum = q;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic cql_pkg::in_item_t make_ack(int acc, logic [31:0] inst,
                                                 logic [15:0] bal, logic [31:0] hnd,
                                                 logic [15:0] len);
    cql_pkg::in_item_t it;
    it.acceptor_index  = acc[1:0];
    it.instance_number = inst;
    it.ballot_number   = bal;
    it.value_handle    = hnd;
    it.value_length    = len;
    return it;
  endfunction

  // Random ack: mostly acks near the delivery point with few ballots, so
  // quorums form out of order and runs are delivered; the rest is noise.
  function automatic cql_pkg::in_item_t random_ack();
    cql_pkg::in_item_t it;
    it = make_ack($urandom_range(0, 2), lrn_through + $urandom_range(1, 6),
                  16'($urandom_range(0, 3)), $urandom, 16'($urandom_range(0, 65535)));
    if ($urandom_range(0, 9) == 0) it.acceptor_index = 2'd3;
    if ($urandom_range(0, 9) == 0) it.ballot_number = 16'($urandom);
    if ($urandom_range(0, 7) == 0) it.instance_number = $urandom;
    if ($urandom_range(0, 15) == 0) it.instance_number = lrn_through + cql_pkg::WINDOW - 1;
    return it;
  endfunction

  table_row_t directed[$];
  logic [1:0] phase_quorum[4] = '{2'd1, 2'd3, 2'd0, 2'd2};

  initial begin
    int n;
    learner_reset();
    // bad acceptor, below the window, past the window edge
    directed.push_back('{make_ack(3, 1, 0, 32'h1, 1), 0});
    directed.push_back('{make_ack(0, 0, 0, 32'h2, 2), 0});
    directed.push_back('{make_ack(0, 64, 0, 32'h3, 3), 0});
    // instance 2 closes ahead of instance 1
    directed.push_back('{make_ack(0, 2, 5, 32'hA, 10), 0});
    directed.push_back('{make_ack(1, 2, 5, 32'hB, 11), 0});
    directed.push_back('{make_ack(0, 1, 0, 32'h0, 16'h0), 0});
    directed.push_back('{make_ack(0, 1, 0, 32'h5, 5), 0});       // duplicate ballot
    directed.push_back('{make_ack(2, 1, 0, 32'hFFFF_FFFF, 16'hFFFF), 2}); // run 1..2
    // newer ballot overtakes, then a matching ack completes it
    directed.push_back('{make_ack(0, 3, 7, 32'h30, 30), 0});
    directed.push_back('{make_ack(1, 3, 9, 32'h31, 31), 0});
    directed.push_back('{make_ack(0, 3, 9, 32'h32, 32), 1});
    directed.push_back('{make_ack(2, 3, 9, 32'h33, 33), 0});     // already delivered
    // far end of the window, ballot at its top; late ack on a closed slot
    directed.push_back('{make_ack(0, 66, 16'hFFFF, 32'h66, 66), 0});
    directed.push_back('{make_ack(2, 66, 16'hFFFF, 32'h67, 67), 0});
    directed.push_back('{make_ack(1, 66, 16'hFFFF, 32'h68, 68), 0});
    directed.push_back('{make_ack(1, 4, 1, 32'h40, 40), DONT_CARE});
    directed.push_back('{make_ack(0, 4, 1, 32'h41, 41), 1});
    directed.push_back('{make_ack(2, 5, 16'h8000, 32'h8000_0000, 16'h8000), DONT_CARE});

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      send_ack(directed[i].ack, n);
      if (directed[i].n_deliv != DONT_CARE && n != directed[i].n_deliv) begin
        $error("deliveries of row %0d: expected %0d, got %0d", i, directed[i].n_deliv, n);
        fail_count++;
      end
    end
    drain();  // sender holds off until every delivery is out

    foreach (phase_quorum[p]) begin
      write_quorum(phase_quorum[p]);
      repeat (40) send_ack(random_ack(), n);
    end

    drain();
    if (fail_count == 0) begin
      $display("consensus_quorum_learner test passed");
    end else begin
      $display("consensus_quorum_learner test failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("consensus_quorum_learner test failed");
    $finish;
  end

endmodule
